### design/sha256_64byte_message_digest_unit_defines.svh
// Assertion macros used by the digest unit's controller
`ifndef SHA256_64BYTE_MESSAGE_DIGEST_UNIT_DEFINES_SVH
`define SHA256_64BYTE_MESSAGE_DIGEST_UNIT_DEFINES_SVH

// Plain property check, off during reset
`define S256MD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("s256md check failed");

// Same-cycle implication, off during reset
`define S256MD_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("s256md implication failed");

`endif

### design/s256md_pkg.sv
// Types, constants and functions of the SHA-256 digest unit
`default_nettype none
package s256md_pkg;

   typedef logic [31:0] word_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       load;       // shift a message word into the schedule
      logic       init;       // load initial value into working and chaining vars
      logic       round;      // one compression round
      logic       fin1;       // end of message block: add back, load padding block
      logic       fin2;       // end of padding block: add into chaining vars
      logic       shift;      // move to the next digest word
      logic [5:0] round_idx;  // round number within the block
   } cmd_type;

   localparam word_type IV_TABLE [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   localparam word_type PAD_FIRST = 32'h80000000;
   localparam word_type PAD_LAST  = 32'h00000200;

   localparam word_type K_TABLE [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type rotr(input word_type x, input int unsigned r);
      rotr = (x >> r) | (x << (32 - r));
   endfunction

   // Round functions
   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   // Schedule functions
   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage
`default_nettype wire

### design/s256md_datapath.sv
// Datapath: message schedule, round logic and chaining registers
`default_nettype none
module s256md_datapath (
   input  wire logic               clock,
   input  wire s256md_pkg::cmd_type cmd,
   input  wire s256md_pkg::word_type msg_word,
   output      s256md_pkg::word_type digest_word
);
   import s256md_pkg::*;

   word_type w_ff [16];
   word_type w_in [16];
   word_type v_ff [8];
   word_type v_in [8];
   word_type h_ff [8];
   word_type h_in [8];

   word_type w_next;
   word_type t1;
   word_type t2;
   word_type ch;
   word_type maj;

   // Rolling schedule: w_ff[0] is the word of the current round
   assign w_next = small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];

   // One round
   assign ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1  = v_ff[7] + big_sigma1(v_ff[4]) + ch + K_TABLE[cmd.round_idx] + w_ff[0];
   assign t2  = big_sigma0(v_ff[0]) + maj;

   // Next values of the schedule
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         w_in[i] = w_ff[i];
      end
      if (cmd.load) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[15] = msg_word;
      end else if (cmd.round) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[15] = w_next;
      end else if (cmd.fin1) begin
         for (int i = 0; i < 16; i++) begin
            w_in[i] = '0;
         end
         w_in[0]  = PAD_FIRST;
         w_in[15] = PAD_LAST;
      end
   end

   // Next values of working and chaining variables
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         v_in[i] = v_ff[i];
         h_in[i] = h_ff[i];
      end
      if (cmd.init) begin
         for (int i = 0; i < 8; i++) begin
            v_in[i] = IV_TABLE[i];
            h_in[i] = IV_TABLE[i];
         end
      end else if (cmd.round) begin
         for (int i = 1; i < 8; i++) begin
            v_in[i] = v_ff[i - 1];
         end
         v_in[0] = t1 + t2;
         v_in[4] = v_ff[3] + t1;
      end else if (cmd.fin1) begin
         for (int i = 0; i < 8; i++) begin
            v_in[i] = h_ff[i] + v_ff[i];
            h_in[i] = h_ff[i] + v_ff[i];
         end
      end else if (cmd.fin2) begin
         for (int i = 0; i < 8; i++) begin
            h_in[i] = h_ff[i] + v_ff[i];
         end
      end else if (cmd.shift) begin
         for (int i = 0; i < 7; i++) begin
            h_in[i] = h_ff[i + 1];
         end
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         w_ff[i] <= w_in[i];
      end
      for (int i = 0; i < 8; i++) begin
         v_ff[i] <= v_in[i];
         h_ff[i] <= h_in[i];
      end
   end

   assign digest_word = h_ff[0];

endmodule
`default_nettype wire

### design/s256md_ctrl.sv
// Controller: word counting, round sequencing and result handshake
`default_nettype none
module s256md_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output      logic                req_tready,
   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   output      logic                rsp_tlast,
   output      s256md_pkg::cmd_type cmd
);
   import s256md_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD, ST_RND1, ST_FIN1, ST_RND2, ST_FIN2, ST_OUT
   } state_type;

   state_type  state_ff;
   logic [3:0] word_ff;
   logic [5:0] round_ff;
   logic [2:0] out_ff;
   logic       valid_ff;

   logic req_hs;
   logic rsp_hs;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_hs     = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_hs     = valid_ff && rsp_tready;
   assign rsp_tlast  = valid_ff && (out_ff == 3'd7);

   // Commands to the datapath
   assign cmd.load      = req_hs;
   assign cmd.init      = req_hs && (word_ff == 4'hF);
   assign cmd.round     = (state_ff == ST_RND1) || (state_ff == ST_RND2);
   assign cmd.fin1      = (state_ff == ST_FIN1);
   assign cmd.fin2      = (state_ff == ST_FIN2);
   assign cmd.shift     = rsp_hs;
   assign cmd.round_idx = round_ff;

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         word_ff  <= '0;
         round_ff <= '0;
         out_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_LOAD: begin
               if (req_hs) begin
                  word_ff <= word_ff + 4'd1;
                  if (word_ff == 4'hF) begin
                     round_ff <= '0;
                     state_ff <= ST_RND1;
                  end
               end
            end
            ST_RND1: begin
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'd63) begin
                  state_ff <= ST_FIN1;
               end
            end
            ST_FIN1: begin
               round_ff <= '0;
               state_ff <= ST_RND2;
            end
            ST_RND2: begin
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'd63) begin
                  state_ff <= ST_FIN2;
               end
            end
            ST_FIN2: begin
               out_ff   <= '0;
               valid_ff <= 1'b1;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_hs) begin
                  out_ff <= out_ff + 3'd1;
                  if (out_ff == 3'd7) begin
                     valid_ff <= 1'b0;
                     state_ff <= ST_LOAD;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

`include "sha256_64byte_message_digest_unit_defines.svh"

   `S256MD_ASSERT(a_no_overlap, clock, reset, !(req_tready && rsp_tvalid))
   `S256MD_ASSERT(a_one_cmd, clock, reset, $onehot0({cmd.init, cmd.round, cmd.fin1, cmd.fin2, cmd.shift}))
   `S256MD_IMPLY(a_fin_after_rounds, clock, reset, cmd.fin1 || cmd.fin2, $past(round_ff) == 6'd63)

endmodule
`default_nettype wire

### design/sha256_64byte_message_digest_unit.sv
// SHA-256 digest unit for fixed 64-byte messages (top level)
// Takes sixteen big-endian 32-bit message words, one per item, then hashes the
// message block from the standard initial value and the fixed padding block,
// one round per clock, and returns digest words H0..H7 with tlast on H7. A
// message is taken as 16 input words, then compressed by the single round
// unit in 64 rounds, an add-back step, 64 rounds and an add step, and its
// digest is read out as 8 output words. Input is not taken while a message
// is being hashed or its digest read.
`default_nettype none
module sha256_64byte_message_digest_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] message_word
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [31:0] digest_word
   output      logic        rsp_tlast    // last_word
);
   import s256md_pkg::*;

   cmd_type cmd;

   s256md_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd)
   );

   s256md_datapath u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .msg_word    (req_tdata),
      .digest_word (rsp_tdata)
   );

endmodule
`default_nettype wire
